// ----- src/b2ad_pkg.sv -----
`default_nettype none

package b2ad_pkg;

    localparam int DIGITS = 8;
    localparam int VALUE_W = 32;
    localparam int NIBBLE_W = 4;
    localparam int ASCII_W = 6;
    localparam int BCD_W = DIGITS * NIBBLE_W;

    localparam logic [ASCII_W-1:0] ASCII_ZERO = ASCII_W'(8'h30);
    localparam logic [NIBBLE_W-1:0] ADJUST_MIN = NIBBLE_W'(5);
    localparam logic [NIBBLE_W-1:0] ADJUST_ADD = NIBBLE_W'(3);
    localparam logic [NIBBLE_W-1:0] DIGIT_MAX = NIBBLE_W'(9);

    function automatic longint unsigned pow10(input int n);
        longint unsigned acc;
        acc = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            acc = acc * 64'd10;
        end
        return acc;
    endfunction

    localparam longint unsigned LIMIT = pow10(DIGITS) - 64'd1;
    localparam int LIMIT_BITS = $clog2(LIMIT + 64'd1);
    localparam int BIN_W = (LIMIT_BITS > VALUE_W) ? VALUE_W : LIMIT_BITS;

    typedef struct packed {
        logic ovf;
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } cell_data_t;

    function automatic logic [ASCII_W-1:0] to_ascii(input logic [NIBBLE_W-1:0] nib);
        return ASCII_ZERO | {{(ASCII_W-NIBBLE_W){1'b0}}, nib};
    endfunction

    function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (bcd[k*NIBBLE_W +: NIBBLE_W] > DIGIT_MAX)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ----- src/b2ad_in_if.sv -----
`default_nettype none

interface b2ad_in_if;
    import b2ad_pkg::*;

    logic valid;
    logic ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- src/b2ad_out_if.sv -----
`default_nettype none

interface b2ad_out_if;
    import b2ad_pkg::*;

    logic valid;
    logic ready;
    logic [ASCII_W-1:0] digit_tens_millions;
    logic [ASCII_W-1:0] digit_millions;
    logic [ASCII_W-1:0] digit_hundred_thousands;
    logic [ASCII_W-1:0] digit_ten_thousands;
    logic [ASCII_W-1:0] digit_thousands;
    logic [ASCII_W-1:0] digit_hundreds;
    logic [ASCII_W-1:0] digit_tens;
    logic [ASCII_W-1:0] digit_units;
    logic overflow;

    modport source (
        output valid,
        input ready,
        output digit_tens_millions,
        output digit_millions,
        output digit_hundred_thousands,
        output digit_ten_thousands,
        output digit_thousands,
        output digit_hundreds,
        output digit_tens,
        output digit_units,
        output overflow
    );
    modport sink (
        input valid,
        output ready,
        input digit_tens_millions,
        input digit_millions,
        input digit_hundred_thousands,
        input digit_ten_thousands,
        input digit_thousands,
        input digit_hundreds,
        input digit_tens,
        input digit_units,
        input overflow
    );
endinterface

`default_nettype wire

// ----- src/binary_to_ascii_decimal_8.sv -----
`default_nettype none

// Converts one unsigned 32-bit value per transfer into eight ASCII decimal
// characters, most significant first, with leading zeros. Values above
// 99999999 give all nines and set overflow. The converter is a chain of 27
// shift-and-adjust cells, one per bit of the clamped value, so a new value is
// taken every cycle while the output side is ready. The result passes through
// every cell register in turn before the output transfer. Each cell holds one
// item, so stalls on the output fill the chain back toward the input without
// losing any transfer.
module binary_to_ascii_decimal_8 (
    input  wire logic   clk,
    input  wire logic   rst_n,
    b2ad_in_if.sink     operand,
    b2ad_out_if.source  result
);
    import b2ad_pkg::*;

    logic       link_valid [BIN_W+1];
    logic       link_ready [BIN_W+1];
    cell_data_t link_data  [BIN_W+1];
    logic       ovf;

    assign ovf = {{(64-VALUE_W){1'b0}}, operand.value} > LIMIT;

    assign link_valid[0]     = operand.valid;
    assign operand.ready     = link_ready[0];
    assign link_data[0].ovf  = ovf;
    assign link_data[0].bcd  = '0;
    assign link_data[0].bin  = ovf ? LIMIT[BIN_W-1:0] : operand.value[BIN_W-1:0];

    for (genvar i = 0; i < BIN_W; i++)
    begin : g_cell
        b2ad_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[i]),
            .up_ready (link_ready[i]),
            .up_data  (link_data[i]),
            .dn_valid (link_valid[i+1]),
            .dn_ready (link_ready[i+1]),
            .dn_data  (link_data[i+1])
        );
    end

    assign result.valid    = link_valid[BIN_W];
    assign link_ready[BIN_W] = result.ready;
    assign result.overflow = link_data[BIN_W].ovf;

    assign result.digit_tens_millions     =
        to_ascii(link_data[BIN_W].bcd[(DIGITS-1)*NIBBLE_W +: NIBBLE_W]);
    assign result.digit_millions          =
        to_ascii(link_data[BIN_W].bcd[(DIGITS-2)*NIBBLE_W +: NIBBLE_W]);
    assign result.digit_hundred_thousands =
        to_ascii(link_data[BIN_W].bcd[(DIGITS-3)*NIBBLE_W +: NIBBLE_W]);
    assign result.digit_ten_thousands     =
        to_ascii(link_data[BIN_W].bcd[(DIGITS-4)*NIBBLE_W +: NIBBLE_W]);
    assign result.digit_thousands         =
        to_ascii(link_data[BIN_W].bcd[(DIGITS-5)*NIBBLE_W +: NIBBLE_W]);
    assign result.digit_hundreds          =
        to_ascii(link_data[BIN_W].bcd[(DIGITS-6)*NIBBLE_W +: NIBBLE_W]);
    assign result.digit_tens              =
        to_ascii(link_data[BIN_W].bcd[(DIGITS-7)*NIBBLE_W +: NIBBLE_W]);
    assign result.digit_units             =
        to_ascii(link_data[BIN_W].bcd[(DIGITS-8)*NIBBLE_W +: NIBBLE_W]);

endmodule

`default_nettype wire

// ----- src/b2ad_cell.sv -----
`default_nettype none

module b2ad_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire b2ad_pkg::cell_data_t up_data,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output b2ad_pkg::cell_data_t      dn_data
);
    import b2ad_pkg::*;

    logic       valid_reg;
    cell_data_t data_reg;
    cell_data_t data_next;
    logic [BCD_W-1:0] adj;

    // Each cell corrects every digit that would overflow on doubling, then
    // shifts one binary bit into the decimal register.
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            if (up_data.bcd[k*NIBBLE_W +: NIBBLE_W] >= ADJUST_MIN)
            begin
                adj[k*NIBBLE_W +: NIBBLE_W] = up_data.bcd[k*NIBBLE_W +: NIBBLE_W] + ADJUST_ADD;
            end
            else
            begin
                adj[k*NIBBLE_W +: NIBBLE_W] = up_data.bcd[k*NIBBLE_W +: NIBBLE_W];
            end
        end
        data_next.ovf = up_data.ovf;
        data_next.bcd = {adj[BCD_W-2:0], up_data.bin[BIN_W-1]};
        data_next.bin = {up_data.bin[BIN_W-2:0], 1'b0};
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

`ifndef SYNTHESIS
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready) |=> dn_valid)
        else $error("cell lost a transfer");
    a_ovf_carried: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready) |=> dn_data.ovf == $past(up_data.ovf))
        else $error("overflow flag not carried");
    a_bin_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready) |=> dn_data.bin == {$past(up_data.bin[BIN_W-2:0]), 1'b0})
        else $error("binary field not shifted");
    a_bcd_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready && bcd_ok(up_data.bcd)) |=> bcd_ok(dn_data.bcd))
        else $error("decimal digit out of range");
`endif
endmodule

`default_nettype wire

// ----- test/tb_binary_to_ascii_decimal_8.sv -----
`default_nettype none

module tb_binary_to_ascii_decimal_8;
    timeunit 1ns;
    timeprecision 1ps;

    import b2ad_pkg::*;

    typedef struct packed {
        logic [DIGITS-1:0][ASCII_W-1:0] digit;
        logic overflow;
    } decimal_text_t;

    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTED = 40;

    logic clk = 1'b0;
    logic rst_n;
    bit idle_on = 1'b0;

    b2ad_in_if operand_if();
    b2ad_out_if result_if();

    decimal_text_t pending_text[$];
    int mismatches = 0;
    int values_sent = 0;
    int results_checked = 0;
    int overflow_results = 0;

    string place_name[DIGITS] = '{
        "units", "tens", "hundreds", "thousands",
        "ten_thousands", "hundred_thousands", "millions", "tens_millions"
    };

    binary_to_ascii_decimal_8 dut (
        .clk(clk),
        .rst_n(rst_n),
        .operand(operand_if),
        .result(result_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic decimal_text_t decimal_ascii_of(input logic [VALUE_W-1:0] v);
        decimal_text_t text;
        longint unsigned rest;
        rest = 64'(v);
        text.overflow = 1'b0;
        if (rest > LIMIT)
        begin
            rest = LIMIT;
            text.overflow = 1'b1;
        end
        for (int i = 0; i < DIGITS; i++)
        begin
            text.digit[i] = ASCII_ZERO + ASCII_W'(rest % 64'd10);
            rest = rest / 64'd10;
        end
        return text;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        longint unsigned span;
        int places;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                return VALUE_W'($urandom_range(0, LIMIT));
            end
            3, 4:
            begin
                places = $urandom_range(1, DIGITS);
                span = 64'd1;
                repeat (places) span = span * 64'd10;
                return VALUE_W'($urandom_range(0, span - 1));
            end
            5:
            begin
                return VALUE_W'($urandom_range(0, 999));
            end
            6:
            begin
                return VALUE_W'(LIMIT - 16 + $urandom_range(0, 32));
            end
            default:
            begin
                return $urandom();
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            operand_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_if.valid <= 1'b1;
        operand_if.value <= v;
        @(posedge clk);
        while (!operand_if.ready)
        begin
            @(posedge clk);
        end
        pending_text.push_back(decimal_ascii_of(v));
        values_sent++;
    endtask

    task automatic wait_for_results();
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            @(posedge clk);
            if (idle_on && stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                result_if.ready <= 1'b0;
            end
            else
            begin
                stall_left = 0;
                result_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        decimal_text_t got;
        decimal_text_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.digit[7] = result_if.digit_tens_millions;
            got.digit[6] = result_if.digit_millions;
            got.digit[5] = result_if.digit_hundred_thousands;
            got.digit[4] = result_if.digit_ten_thousands;
            got.digit[3] = result_if.digit_thousands;
            got.digit[2] = result_if.digit_hundreds;
            got.digit[1] = result_if.digit_tens;
            got.digit[0] = result_if.digit_units;
            got.overflow = result_if.overflow;
            if (pending_text.size() == 0)
            begin
                report_mismatch("result transfer with no conversion pending");
            end
            else
            begin
                want = pending_text.pop_front();
                results_checked++;
                for (int i = 0; i < DIGITS; i++)
                begin
                    if (got.digit[i] !== want.digit[i])
                    begin
                        report_mismatch($sformatf("digit_%s got 0x%02h expected 0x%02h",
                            place_name[i], got.digit[i], want.digit[i]));
                    end
                end
                if (got.overflow !== want.overflow)
                begin
                    report_mismatch($sformatf("overflow got %b expected %b",
                        got.overflow, want.overflow));
                end
                if (want.overflow)
                begin
                    overflow_results++;
                end
            end
        end
    end

    task automatic test_directed_values();
        logic [VALUE_W-1:0] corner[$];
        idle_on = 1'b0;
        corner = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
            32'd12345678, 32'd98765432, 32'd9999999, 32'd10000000,
            32'd99999998, 32'd99999999, 32'd100000000, 32'd100000001,
            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
            32'd50505050, 32'd87654321, 32'h5555_5555, 32'hAAAA_AAAA
        };
        foreach (corner[i])
        begin
            send_value(corner[i]);
        end
    endtask

    task automatic test_pause_until_drained();
        idle_on = 1'b0;
        repeat (8) send_value(random_value());
        operand_if.valid <= 1'b0;
        wait_for_results();
        @(posedge clk);
        repeat (8) send_value(random_value());
    endtask

    task automatic test_random_with_idling(input int count);
        idle_on = 1'b1;
        repeat (count) send_value(random_value());
    endtask

    task automatic test_random_full_rate(input int count);
        idle_on = 1'b0;
        repeat (count) send_value(random_value());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        operand_if.valid <= 1'b0;
        operand_if.value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_pause_until_drained();
        test_random_with_idling(700);
        test_random_full_rate(200);
        test_random_with_idling(500);
        test_pause_until_drained();
        test_random_full_rate(460);

        operand_if.valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_text.size() != 0)
        begin
            report_mismatch($sformatf("%0d conversions never returned", pending_text.size()));
        end

        $display("Converted %0d values and checked %0d results, %0d of them saturated.",
            values_sent, results_checked, overflow_results);
        $display("Covered edge values, a full drain, and random traffic with and without stalls.");
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Run did not finish in time.");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- binary_to_ascii_decimal_8.f -----
src/b2ad_pkg.sv
src/b2ad_in_if.sv
src/b2ad_out_if.sv
src/b2ad_cell.sv
src/binary_to_ascii_decimal_8.sv
test/tb_binary_to_ascii_decimal_8.sv
